[src/tipa_pkg.sv]
// Package for the typed ID pool allocator: operation and status codes,
// controller/datapath command and status structs. No dependencies.
package tipa_pkg;

   // Operation codes carried in the input item
   typedef enum logic [2:0] {
      OP_GROW        = 3'd0,
      OP_RESERVE     = 3'd1,
      OP_CONSUME     = 3'd2,
      OP_PRE_RELEASE = 3'd3,
      OP_RELEASE     = 3'd4
   } op_type;

   // Result status codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_LIMIT = 3'd1;
   localparam logic [2:0] ST_EMPTY = 3'd2;
   localparam logic [2:0] ST_WARN  = 3'd3;
   localparam logic [2:0] ST_FULL  = 3'd4;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic clear;    // write one mark entry of the clearing pass
      logic capture;  // item accepted: latch fields, issue memory reads
      logic commit;   // apply the item and load the result register
   } tipa_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic clear_last;  // clearing pass is at its last entry
   } tipa_stat_type;

endpackage

[src/tipa_ctrl.sv]
// Controller of the typed ID pool allocator: clearing pass, accept and
// commit sequencing, output valid. Depends on tipa_pkg.
module tipa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  tipa_pkg::tipa_stat_type stat,
   output tipa_pkg::tipa_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   logic      req_tready_ff;
   logic      rsp_tvalid_ff;

   // Commands
   always_comb begin
      cmd.clear   = (state_ff == S_CLEAR);
      cmd.capture = req_tvalid && req_tready_ff;
      cmd.commit  = (state_ff == S_EXEC) && (!rsp_tvalid_ff || rsp_tready);
   end

   // State and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         req_tready_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               if (stat.clear_last) begin
                  state_ff      <= S_IDLE;
                  req_tready_ff <= 1'b1;
               end
            end
            S_IDLE: begin
               if (cmd.capture) begin
                  state_ff      <= S_EXEC;
                  req_tready_ff <= 1'b0;
               end
            end
            S_EXEC: begin
               if (cmd.commit) begin
                  state_ff      <= S_IDLE;
                  req_tready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff      <= S_CLEAR;
               req_tready_ff <= 1'b0;
            end
         endcase

         // Result register occupancy
         if (cmd.commit) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   assign req_tready = req_tready_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

[src/tipa_dp.sv]
// Datapath of the typed ID pool allocator: free and reserved FIFO memories,
// releasing marks, counters and the result register. Depends on tipa_pkg.
module tipa_dp #(
   parameter int MAX_IDS = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tipa_pkg::tipa_cmd_type  cmd,
   output tipa_pkg::tipa_stat_type stat,
   input  logic [2:0]              req_operation,
   input  logic                    req_box_type,
   input  logic [7:0]              req_conn_id,
   input  logic [8:0]              req_grow_limit,
   output logic [7:0]              rsp_result_id,
   output logic [2:0]              rsp_status,
   output logic                    rsp_avail_type0,
   output logic                    rsp_avail_type1,
   output logic                    rsp_reserved_type0,
   output logic                    rsp_reserved_type1
);

   localparam int ID_W       = $clog2(MAX_IDS);
   localparam int CNT_W      = $clog2(MAX_IDS + 1);
   localparam int SUM_W      = CNT_W + 1;
   localparam int CMP_W      = (CNT_W + 1 > 9) ? CNT_W + 1 : 9;
   localparam int MARK_AW    = ID_W + 1;
   localparam int MARK_DEPTH = 2 ** MARK_AW;

   // Pointer step with wrap at MAX_IDS
   function automatic logic [ID_W-1:0] ptr_next(input logic [ID_W-1:0] ptr);
      logic [ID_W-1:0] res;
      res = (ptr == ID_W'(MAX_IDS - 1)) ? '0 : ptr + 1'b1;
      return res;
   endfunction

   // Tail slot: head plus count, modulo MAX_IDS
   function automatic logic [ID_W-1:0] ptr_tail(input logic [ID_W-1:0]  head,
                                                input logic [CNT_W-1:0] count);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(count);
      if (sum >= SUM_W'(MAX_IDS)) begin
         sum = sum - SUM_W'(MAX_IDS);
      end
      return sum[ID_W-1:0];
   endfunction

   // Memories
   logic [ID_W-1:0] free_mem [MAX_IDS];
   logic [ID_W-1:0] res_mem  [MARK_DEPTH];
   logic            mark_mem [MARK_DEPTH];

   // Control state
   logic [ID_W-1:0]    free_head_ff, free_head_in;
   logic [CNT_W-1:0]   free_count_ff, free_count_in;
   logic [ID_W-1:0]    res_head_ff [2];
   logic [ID_W-1:0]    res_head_in [2];
   logic [CNT_W-1:0]   res_count_ff [2];
   logic [CNT_W-1:0]   res_count_in [2];
   logic [CNT_W-1:0]   created_ff [2];
   logic [CNT_W-1:0]   created_in [2];
   logic [CNT_W-1:0]   avail_ff [2];
   logic [CNT_W-1:0]   avail_in [2];
   logic [MARK_AW-1:0] clr_ptr_ff;

   // Captured item and read data
   tipa_pkg::op_type op_ff;
   logic             type_ff;
   logic [7:0]       id_ff;
   logic [8:0]       limit_ff;
   logic [ID_W-1:0]  free_rd_ff;
   logic [ID_W-1:0]  res_rd_ff;
   logic             mark_rd_ff;

   // Result register
   logic [7:0] rsp_id_ff;
   logic [2:0] rsp_status_ff;
   logic [3:0] rsp_flags_ff;

   // Write ports and decode
   logic               free_we;
   logic [ID_W-1:0]    free_waddr;
   logic [ID_W-1:0]    free_wdata;
   logic               res_we;
   logic [MARK_AW-1:0] res_waddr;
   logic               mark_we;
   logic [MARK_AW-1:0] mark_waddr;
   logic               mark_wdata;
   logic [ID_W-1:0]    res_id;
   logic [2:0]         st;
   logic [CMP_W-1:0]   nid;
   logic [CMP_W-1:0]   id_wide;
   logic               id_in_range;
   logic [ID_W-1:0]    id_idx;
   logic [ID_W-1:0]    free_tail;
   logic [ID_W-1:0]    res_tail;
   logic               free_full;
   logic [ID_W-1:0]    req_id_idx;

   assign nid         = CMP_W'(created_ff[0]) + CMP_W'(created_ff[1]);
   assign id_wide     = CMP_W'(id_ff);
   assign id_in_range = id_wide < CMP_W'(MAX_IDS);
   assign id_idx      = id_wide[ID_W-1:0];
   assign free_tail   = ptr_tail(free_head_ff, free_count_ff);
   assign res_tail    = ptr_tail(res_head_ff[type_ff], res_count_ff[type_ff]);
   assign free_full   = (free_count_ff == CNT_W'(MAX_IDS));
   assign req_id_idx  = CMP_W'(req_conn_id) < CMP_W'(MAX_IDS) ?
                        ID_W'(req_conn_id) : '0;

   // Operation decode and next state
   always_comb begin
      free_head_in  = free_head_ff;
      free_count_in = free_count_ff;
      res_head_in   = res_head_ff;
      res_count_in  = res_count_ff;
      created_in    = created_ff;
      avail_in      = avail_ff;
      free_we       = 1'b0;
      free_waddr    = free_tail;
      free_wdata    = nid[ID_W-1:0];
      res_we        = 1'b0;
      res_waddr     = {type_ff, res_tail};
      mark_we       = 1'b0;
      mark_waddr    = {type_ff, id_idx};
      mark_wdata    = 1'b0;
      res_id        = '0;
      st            = tipa_pkg::ST_OK;

      if (cmd.commit) begin
         unique case (op_ff)
            tipa_pkg::OP_GROW: begin
               if (CMP_W'(created_ff[type_ff]) >= CMP_W'(limit_ff)) begin
                  st = tipa_pkg::ST_LIMIT;
               end else if (nid >= CMP_W'(MAX_IDS) || free_full) begin
                  st = tipa_pkg::ST_FULL;
               end else begin
                  free_we             = 1'b1;
                  free_count_in       = free_count_ff + 1'b1;
                  created_in[type_ff] = created_ff[type_ff] + 1'b1;
                  avail_in[type_ff]   = avail_ff[type_ff] + 1'b1;
                  res_id              = nid[ID_W-1:0];
               end
            end
            tipa_pkg::OP_RESERVE: begin
               if (free_count_ff == '0 || avail_ff[type_ff] == '0) begin
                  st = tipa_pkg::ST_EMPTY;
               end else if (res_count_ff[type_ff] == CNT_W'(MAX_IDS)) begin
                  st = tipa_pkg::ST_FULL;
               end else begin
                  res_id                = free_rd_ff;
                  free_head_in          = ptr_next(free_head_ff);
                  free_count_in         = free_count_ff - 1'b1;
                  avail_in[type_ff]     = avail_ff[type_ff] - 1'b1;
                  res_we                = 1'b1;
                  res_count_in[type_ff] = res_count_ff[type_ff] + 1'b1;
               end
            end
            tipa_pkg::OP_CONSUME: begin
               if (res_count_ff[type_ff] == '0) begin
                  st = tipa_pkg::ST_EMPTY;
               end else begin
                  res_id                = res_rd_ff;
                  res_head_in[type_ff]  = ptr_next(res_head_ff[type_ff]);
                  res_count_in[type_ff] = res_count_ff[type_ff] - 1'b1;
               end
            end
            tipa_pkg::OP_PRE_RELEASE: begin
               if (id_in_range) begin
                  mark_we    = 1'b1;
                  mark_wdata = 1'b1;
               end
            end
            tipa_pkg::OP_RELEASE: begin
               if (!id_in_range) begin
                  st = tipa_pkg::ST_WARN;
               end else if (free_full) begin
                  st = tipa_pkg::ST_FULL;
               end else begin
                  st                = mark_rd_ff ? tipa_pkg::ST_OK : tipa_pkg::ST_WARN;
                  mark_we           = 1'b1;
                  avail_in[type_ff] = avail_ff[type_ff] + 1'b1;
                  free_we           = 1'b1;
                  free_wdata        = id_idx;
                  free_count_in     = free_count_ff + 1'b1;
               end
            end
            default: begin
               st = tipa_pkg::ST_OK;
            end
         endcase
      end

      // Clearing pass owns the mark write port
      if (cmd.clear) begin
         mark_we    = 1'b1;
         mark_waddr = clr_ptr_ff;
         mark_wdata = 1'b0;
      end
   end

   assign stat.clear_last = (clr_ptr_ff == '1);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff  <= '0;
         free_count_ff <= '0;
         res_head_ff   <= '{default: '0};
         res_count_ff  <= '{default: '0};
         created_ff    <= '{default: '0};
         avail_ff      <= '{default: '0};
         clr_ptr_ff    <= '0;
      end else begin
         free_head_ff  <= free_head_in;
         free_count_ff <= free_count_in;
         res_head_ff   <= res_head_in;
         res_count_ff  <= res_count_in;
         created_ff    <= created_in;
         avail_ff      <= avail_in;
         if (cmd.clear) begin
            clr_ptr_ff <= clr_ptr_ff + 1'b1;
         end
      end
   end

   // Item capture and registered memory reads at accept
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= tipa_pkg::op_type'(req_operation);
         type_ff    <= req_box_type;
         id_ff      <= req_conn_id;
         limit_ff   <= req_grow_limit;
         free_rd_ff <= free_mem[free_head_ff];
         res_rd_ff  <= res_mem[{req_box_type, res_head_ff[req_box_type]}];
         mark_rd_ff <= mark_mem[{req_box_type, req_id_idx}];
      end
   end

   // Memory writes
   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[free_waddr] <= free_wdata;
      end
      if (res_we) begin
         res_mem[res_waddr] <= free_rd_ff;
      end
      if (mark_we) begin
         mark_mem[mark_waddr] <= mark_wdata;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_id_ff     <= 8'(res_id);
         rsp_status_ff <= st;
         rsp_flags_ff  <= {res_count_in[1] != '0, res_count_in[0] != '0,
                           avail_in[1] != '0, avail_in[0] != '0};
      end
   end

   assign rsp_result_id      = rsp_id_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_avail_type0    = rsp_flags_ff[0];
   assign rsp_avail_type1    = rsp_flags_ff[1];
   assign rsp_reserved_type0 = rsp_flags_ff[2];
   assign rsp_reserved_type1 = rsp_flags_ff[3];

endmodule

[src/typed_id_pool_allocator.sv]
// Top level of the typed ID pool allocator: controller plus datapath.
// Depends on tipa_pkg, tipa_ctrl and tipa_dp.
//
//   channel   direction   payload
//   req_*     in          tuser: operation[2:0], box_type[3]
//                         tdata: conn_id[7:0], grow_limit[16:8]
//   rsp_*     out         tdata: result_id[7:0], status[10:8], avail_type0[11],
//                         avail_type1[12], reserved_type0[13], reserved_type1[14]
//
// Each item is handled in turn: the accept edge issues the FIFO and mark memory
// reads; S_EXEC then applies the item, loads the result register and re-opens req_tready.
// After reset a clearing pass writes every releasing mark, 2 * 2**clog2(MAX_IDS)
// entries (512 at the default), with req_tready low.
// A result waiting on rsp_tready does not block the next accept; that item's
// commit waits until the result register is free.
module typed_id_pool_allocator #(
   parameter int MAX_IDS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // conn_id[7:0], grow_limit[16:8], zero[23:17]
   input  logic [3:0]  req_tuser,   // operation[2:0], box_type[3]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // result_id[7:0], status[10:8], avail_type0[11],
                                    // avail_type1[12], reserved_type0[13],
                                    // reserved_type1[14], zero[15]
);

   tipa_pkg::tipa_cmd_type  cmd;
   tipa_pkg::tipa_stat_type stat;

   logic [7:0] rsp_result_id;
   logic [2:0] rsp_status;
   logic       rsp_avail_type0;
   logic       rsp_avail_type1;
   logic       rsp_reserved_type0;
   logic       rsp_reserved_type1;

   tipa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tipa_dp #(
      .MAX_IDS (MAX_IDS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_operation      (req_tuser[2:0]),
      .req_box_type       (req_tuser[3]),
      .req_conn_id        (req_tdata[7:0]),
      .req_grow_limit     (req_tdata[16:8]),
      .rsp_result_id      (rsp_result_id),
      .rsp_status         (rsp_status),
      .rsp_avail_type0    (rsp_avail_type0),
      .rsp_avail_type1    (rsp_avail_type1),
      .rsp_reserved_type0 (rsp_reserved_type0),
      .rsp_reserved_type1 (rsp_reserved_type1)
   );

   // Pack the result item
   assign rsp_tdata = {1'b0, rsp_reserved_type1, rsp_reserved_type0, rsp_avail_type1,
                       rsp_avail_type0, rsp_status, rsp_result_id};

endmodule
